// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define IVM_ASSERT_NOW(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

// Check that an antecedent is followed in the next cycle by a consequent.
`define IVM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/ivm_pkg.sv =====
// ----------------------------------------------------------------------------
// ivm_pkg
// Shared constants, request codes and the command and status bundles that
// join the mixer controller to its datapath.
// ----------------------------------------------------------------------------
package ivm_pkg;

    localparam int NUM_VOICES   = 16;
    localparam int SAMPLE_DEPTH = 65536;
    localparam int FRAC_BITS    = 16;

    localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W  = 17;
    localparam int SPD_W  = 24;
    localparam int POS_W  = ((LEN_W + FRAC_BITS) > SPD_W ? (LEN_W + FRAC_BITS) : SPD_W) + 1;
    localparam int IP_W   = POS_W - FRAC_BITS;
    // largest shift of the end mark needed to reduce a wrapped position
    localparam int DIV_TOP = (SPD_W > FRAC_BITS) ? (SPD_W - FRAC_BITS) : 0;
    localparam int DK_W    = (DIV_TOP > 0) ? $clog2(DIV_TOP + 1) : 1;
    localparam int DIV_W   = POS_W + DIV_TOP + 1;
    localparam int T_W     = FRAC_BITS + 18;
    localparam int P_W     = T_W + 17;
    localparam int N_W     = P_W + 2;

    localparam int PCM_MAX = (1 << (16 - 1)) - 1;
    localparam int PCM_MIN = -(1 << (16 - 1));

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_WRITE    = 3'd1,
        REQ_SET      = 3'd2,
        REQ_PLAY     = 3'd3,
        REQ_STOP     = 3'd4,
        REQ_STOP_ALL = 3'd5,
        REQ_GROUP    = 3'd6,
        REQ_QUERY    = 3'd7
    } ivm_req_t;

    typedef struct packed {
        logic       load;
        logic       tick_init;
        logic       vnext;
        logic       rd_en;
        logic [1:0] rd_k;
        logic       cap_s0;
        logic       cap_s1;
        logic       cap_s2;
        logic       interp;
        logic       side_r;
        logic       mult;
        logic       accum;
        logic       adv;
        logic       div_init;
        logic       div_step;
        logic       pos_wb;
        logic       stop_cur;
        logic       scan_init;
        logic       scan_next;
        logic       start_scan;
        logic       start_fallback;
        logic       do_write;
        logic       do_set;
        logic       do_play;
        logic       do_stop;
        logic       do_stop_all;
        logic       res_load;
    } ivm_cmd_t;

    typedef struct packed {
        ivm_req_t req;
        logic     play_cur;
        logic     vidx_last;
        logic     ge_end;
        logic     loop_cur;
        logic     div_last;
        logic     scan_hit;
        logic     scan_end;
    } ivm_stat_t;

endpackage

// ===== hdl/ivm_datapath.sv =====
// ----------------------------------------------------------------------------
// ivm_datapath
// Sample store, voice registers, interpolation, gain and saturating mix.
// ----------------------------------------------------------------------------
module ivm_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ivm_pkg::ivm_cmd_t     cmd,
    output ivm_pkg::ivm_stat_t    stat,
    input  logic [2:0]            in_req_type,
    input  logic [3:0]            in_voice,
    input  logic [3:0]            in_voice_last,
    input  logic [15:0]           in_sample_addr,
    input  logic signed [15:0]    in_sample_value,
    input  logic [15:0]           in_base_addr,
    input  logic [16:0]           in_length,
    input  logic [15:0]           in_volume,
    input  logic [23:0]           in_speed,
    input  logic                  in_loop_enable,
    output logic signed [15:0]    out_left,
    output logic signed [15:0]    out_right,
    output logic [3:0]            out_voice_started,
    output logic                  out_playing
);

    // latched request
    ivm_pkg::ivm_req_t                   req_reg;
    logic [3:0]                          voice_reg;
    logic [3:0]                          vlast_reg;
    logic [15:0]                         saddr_reg;
    logic signed [15:0]                  sval_reg;
    logic [15:0]                         base_in_reg;
    logic [ivm_pkg::LEN_W-1:0]           len_in_reg;
    logic [15:0]                         vol_in_reg;
    logic [ivm_pkg::SPD_W-1:0]           spd_in_reg;
    logic                                loop_in_reg;

    // voice state
    logic [15:0]                  base_reg [ivm_pkg::NUM_VOICES];
    logic [ivm_pkg::LEN_W-1:0]    len_reg  [ivm_pkg::NUM_VOICES];
    logic [ivm_pkg::POS_W-1:0]    pos_reg  [ivm_pkg::NUM_VOICES];
    logic [ivm_pkg::SPD_W-1:0]    spd_reg  [ivm_pkg::NUM_VOICES];
    logic [15:0]                  gain_reg [ivm_pkg::NUM_VOICES];
    logic [ivm_pkg::NUM_VOICES-1:0] loop_reg;
    logic [ivm_pkg::NUM_VOICES-1:0] play_reg;

    logic [15:0]                  mem [ivm_pkg::SAMPLE_DEPTH];
    logic signed [15:0]           rdata_reg;

    logic [ivm_pkg::VIDX_W-1:0]   vidx_reg;
    logic [ivm_pkg::VIDX_W:0]     scan_reg;
    logic [3:0]                   started_reg;
    logic signed [15:0]           s0_reg, s1_reg, s2_reg;
    logic signed [ivm_pkg::T_W-1:0] t_reg;
    logic signed [ivm_pkg::P_W-1:0] prod_reg;
    logic signed [15:0]           acc_l_reg, acc_r_reg;
    logic [ivm_pkg::POS_W-1:0]    posw_reg;
    logic [ivm_pkg::DK_W-1:0]     dk_reg;

    logic [ivm_pkg::VIDX_W-1:0]   vsel;
    logic                         voice_ok;
    logic [ivm_pkg::LEN_W-1:0]    eff_len;
    logic [ivm_pkg::POS_W-1:0]    cur_pos;
    logic [ivm_pkg::IP_W:0]       idx0, idx1, idx2, len_x;
    logic [ivm_pkg::ADDR_W-1:0]   rd_addr;
    logic [ivm_pkg::FRAC_BITS-1:0] fr;
    logic signed [15:0]           ia, ib;
    logic signed [16:0]           diff;
    logic signed [ivm_pkg::FRAC_BITS:0] frs;
    logic signed [ivm_pkg::T_W-1:0] interp_val;
    logic signed [ivm_pkg::N_W-1:0] num, quo;
    logic signed [15:0]           acc_cur, acc_new;
    logic [ivm_pkg::POS_W-1:0]    end_mark;
    logic [ivm_pkg::DIV_W-1:0]    div_sub;
    logic [ivm_pkg::VIDX_W-1:0]   scan_idx;
    logic                         query_play;

    assign vsel     = ivm_pkg::VIDX_W'(voice_reg);
    assign voice_ok = (32'(voice_reg) < ivm_pkg::NUM_VOICES);
    assign scan_idx = scan_reg[ivm_pkg::VIDX_W-1:0];

    // read index of the current voice, wrapped at the sound length
    always_comb begin
        eff_len  = (len_reg[vidx_reg] == '0) ? ivm_pkg::LEN_W'(1) : len_reg[vidx_reg];
        cur_pos  = pos_reg[vidx_reg];
        fr       = cur_pos[ivm_pkg::FRAC_BITS-1:0];
        len_x    = (ivm_pkg::IP_W+1)'(eff_len);
        idx0     = (ivm_pkg::IP_W+1)'(cur_pos[ivm_pkg::POS_W-1:ivm_pkg::FRAC_BITS])
                   + (ivm_pkg::IP_W+1)'(cmd.rd_k);
        idx1     = (idx0 >= len_x) ? idx0 - len_x : idx0;
        idx2     = (idx1 >= len_x) ? idx1 - len_x : idx1;
        rd_addr  = ivm_pkg::ADDR_W'(idx2 + (ivm_pkg::IP_W+1)'(base_reg[vidx_reg]));
        end_mark = ivm_pkg::POS_W'(eff_len) << ivm_pkg::FRAC_BITS;
        div_sub  = ivm_pkg::DIV_W'(end_mark) << dk_reg;
    end

    // linear interpolation between two neighbouring samples
    always_comb begin
        ia         = cmd.side_r ? s1_reg : s0_reg;
        ib         = cmd.side_r ? s2_reg : s1_reg;
        diff       = 17'(ib) - 17'(ia);
        frs        = $signed({1'b0, fr});
        interp_val = (ivm_pkg::T_W'(ia) <<< ivm_pkg::FRAC_BITS)
                     + ivm_pkg::T_W'(frs * diff);
    end

    // add to the channel sum, truncate toward zero, saturate
    always_comb begin
        acc_cur = cmd.side_r ? acc_r_reg : acc_l_reg;
        num     = (ivm_pkg::N_W'(acc_cur) <<< (16 + ivm_pkg::FRAC_BITS))
                  + ivm_pkg::N_W'(prod_reg);
        quo     = num >>> (16 + ivm_pkg::FRAC_BITS);
        if (num[ivm_pkg::N_W-1] && (num[16+ivm_pkg::FRAC_BITS-1:0] != '0)) begin
            quo = quo + ivm_pkg::N_W'(1);
        end
        if (quo > ivm_pkg::N_W'(ivm_pkg::PCM_MAX)) begin
            acc_new = 16'(ivm_pkg::PCM_MAX);
        end else if (quo < ivm_pkg::N_W'(ivm_pkg::PCM_MIN)) begin
            acc_new = 16'(ivm_pkg::PCM_MIN);
        end else begin
            acc_new = quo[15:0];
        end
    end

    assign query_play = voice_ok && play_reg[vsel];

    // status back to the controller
    always_comb begin
        stat.req       = req_reg;
        stat.play_cur  = play_reg[vidx_reg];
        stat.vidx_last = (vidx_reg == ivm_pkg::VIDX_W'(ivm_pkg::NUM_VOICES - 1));
        stat.ge_end    = (posw_reg >= end_mark);
        stat.loop_cur  = loop_reg[vidx_reg];
        stat.div_last  = (dk_reg == '0);
        stat.scan_end  = (scan_reg > {1'b0, ivm_pkg::VIDX_W'(vlast_reg)})
                         || (32'(scan_reg) >= ivm_pkg::NUM_VOICES)
                         || (32'(vlast_reg) < 32'(scan_reg));
        stat.scan_hit  = !stat.scan_end && !play_reg[scan_idx];
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (cmd.do_write) begin
            mem[saddr_reg[ivm_pkg::ADDR_W-1:0]] <= sval_reg;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // request latch and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= ivm_pkg::ivm_req_t'(in_req_type);
            voice_reg   <= in_voice;
            vlast_reg   <= in_voice_last;
            saddr_reg   <= in_sample_addr;
            sval_reg    <= in_sample_value;
            base_in_reg <= in_base_addr;
            len_in_reg  <= in_length;
            vol_in_reg  <= in_volume;
            spd_in_reg  <= in_speed;
            loop_in_reg <= in_loop_enable;
        end
        if (cmd.tick_init) begin
            vidx_reg  <= '0;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (cmd.vnext) begin
            vidx_reg <= vidx_reg + ivm_pkg::VIDX_W'(1);
        end
        if (cmd.cap_s0) s0_reg <= rdata_reg;
        if (cmd.cap_s1) s1_reg <= rdata_reg;
        if (cmd.cap_s2) s2_reg <= rdata_reg;
        if (cmd.interp) t_reg <= interp_val;
        if (cmd.mult) begin
            prod_reg <= ivm_pkg::P_W'(t_reg * $signed({1'b0, gain_reg[vidx_reg]}));
        end
        if (cmd.accum) begin
            if (cmd.side_r) acc_r_reg <= acc_new;
            else            acc_l_reg <= acc_new;
        end
        if (cmd.adv) begin
            posw_reg <= cur_pos + ivm_pkg::POS_W'(spd_reg[vidx_reg]);
        end else if (cmd.div_step) begin
            if (ivm_pkg::DIV_W'(posw_reg) >= div_sub) begin
                posw_reg <= posw_reg - ivm_pkg::POS_W'(div_sub);
            end
        end
        if (cmd.div_init) begin
            dk_reg <= ivm_pkg::DK_W'(ivm_pkg::DIV_TOP);
        end else if (cmd.div_step) begin
            dk_reg <= dk_reg - ivm_pkg::DK_W'(1);
        end
        if (cmd.scan_init) begin
            scan_reg <= (ivm_pkg::VIDX_W+1)'(voice_reg);
        end else if (cmd.scan_next) begin
            scan_reg <= scan_reg + (ivm_pkg::VIDX_W+1)'(1);
        end
        if (cmd.start_scan) begin
            started_reg <= 4'(scan_reg);
        end else if (cmd.start_fallback) begin
            started_reg <= voice_reg;
        end
        if (cmd.res_load) begin
            out_left          <= (req_reg == ivm_pkg::REQ_TICK) ? acc_l_reg : '0;
            out_right         <= (req_reg == ivm_pkg::REQ_TICK) ? acc_r_reg : '0;
            out_voice_started <= (req_reg == ivm_pkg::REQ_GROUP) ? started_reg : '0;
            out_playing       <= (req_reg == ivm_pkg::REQ_QUERY) ? query_play : 1'b0;
        end
    end

    // voice state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ivm_pkg::NUM_VOICES; i++) begin
                base_reg[i] <= '0;
                len_reg[i]  <= ivm_pkg::LEN_W'(1);
                pos_reg[i]  <= '0;
                spd_reg[i]  <= ivm_pkg::SPD_W'(1) << ivm_pkg::FRAC_BITS;
                gain_reg[i] <= '0;
            end
            loop_reg <= '0;
            play_reg <= '0;
        end else begin
            if (cmd.do_set && voice_ok) begin
                base_reg[vsel] <= base_in_reg;
                len_reg[vsel]  <= len_in_reg;
                gain_reg[vsel] <= vol_in_reg;
                spd_reg[vsel]  <= spd_in_reg;
                loop_reg[vsel] <= loop_in_reg;
                pos_reg[vsel]  <= '0;
                play_reg[vsel] <= 1'b0;
            end
            if ((cmd.do_play || cmd.start_fallback) && voice_ok) begin
                pos_reg[vsel]  <= '0;
                play_reg[vsel] <= 1'b1;
            end
            if (cmd.do_stop && voice_ok) begin
                pos_reg[vsel]  <= '0;
                play_reg[vsel] <= 1'b0;
            end
            if (cmd.start_scan) begin
                pos_reg[scan_idx]  <= '0;
                play_reg[scan_idx] <= 1'b1;
            end
            if (cmd.do_stop_all) begin
                for (int i = 0; i < ivm_pkg::NUM_VOICES; i++) begin
                    pos_reg[i] <= '0;
                end
                play_reg <= '0;
            end
            if (cmd.pos_wb) begin
                pos_reg[vidx_reg] <= posw_reg;
            end
            if (cmd.stop_cur) begin
                pos_reg[vidx_reg]  <= '0;
                play_reg[vidx_reg] <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/ivm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ivm_ctrl
// Sequencer for the mixer: decodes each request, walks the voices on a tick
// and hands the result beat to the output register.
// ----------------------------------------------------------------------------
module ivm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  ivm_pkg::ivm_stat_t    stat,
    output ivm_pkg::ivm_cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISP, ST_VSEL, ST_RD0, ST_RD1, ST_RD2, ST_INTL, ST_MULL,
        ST_ACCL, ST_INTR, ST_MULR, ST_ACCR, ST_ADV, ST_CHK, ST_DIV, ST_WB,
        ST_VNXT, ST_SCAN, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                state_next = ST_DONE;
                case (stat.req)
                    ivm_pkg::REQ_TICK: begin
                        cmd.tick_init = 1'b1;
                        state_next    = ST_VSEL;
                    end
                    ivm_pkg::REQ_WRITE:    cmd.do_write    = 1'b1;
                    ivm_pkg::REQ_SET:      cmd.do_set      = 1'b1;
                    ivm_pkg::REQ_PLAY:     cmd.do_play     = 1'b1;
                    ivm_pkg::REQ_STOP:     cmd.do_stop     = 1'b1;
                    ivm_pkg::REQ_STOP_ALL: cmd.do_stop_all = 1'b1;
                    ivm_pkg::REQ_GROUP: begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    default: ;
                endcase
            end
            ST_VSEL: begin
                if (stat.play_cur) begin
                    state_next = ST_RD0;
                end else if (stat.vidx_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.vnext = 1'b1;
                end
            end
            ST_RD0: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = 2'd0;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = 2'd1;
                cmd.cap_s0 = 1'b1;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = 2'd2;
                cmd.cap_s1 = 1'b1;
                state_next = ST_INTL;
            end
            ST_INTL: begin
                cmd.cap_s2 = 1'b1;
                cmd.interp = 1'b1;
                state_next = ST_MULL;
            end
            ST_MULL: begin
                cmd.mult   = 1'b1;
                state_next = ST_ACCL;
            end
            ST_ACCL: begin
                cmd.accum  = 1'b1;
                state_next = ST_INTR;
            end
            ST_INTR: begin
                cmd.interp = 1'b1;
                cmd.side_r = 1'b1;
                state_next = ST_MULR;
            end
            ST_MULR: begin
                cmd.mult   = 1'b1;
                state_next = ST_ACCR;
            end
            ST_ACCR: begin
                cmd.accum  = 1'b1;
                cmd.side_r = 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV: begin
                cmd.adv    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (!stat.ge_end) begin
                    state_next = ST_WB;
                end else if (stat.loop_cur) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.stop_cur = 1'b1;
                    state_next   = ST_VNXT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.pos_wb = 1'b1;
                state_next = ST_VNXT;
            end
            ST_VNXT: begin
                if (stat.vidx_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.vnext  = 1'b1;
                    state_next = ST_VSEL;
                end
            end
            ST_SCAN: begin
                if (stat.scan_hit) begin
                    cmd.start_scan = 1'b1;
                    state_next     = ST_DONE;
                end else if (stat.scan_end) begin
                    cmd.start_fallback = 1'b1;
                    state_next         = ST_DONE;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/interpolating_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// interpolating_voice_mixer
// Multi-voice sample playback mixer with linear interpolation and 16-bit
// saturating stereo mix.
// ----------------------------------------------------------------------------
// Channel  | Dir | tdata                                  | tuser
// s_       | in  | request fields, 120 bits               | req_type
// m_       | out | left, right, voice_started, playing    | -
//
// A tick visits every voice in turn. A playing voice reads three samples one
// after another through the single sample store read port, interpolates, scales
// and adds the left and then the right channel, and advances its position; a
// voice that wraps at its loop end adds a restoring reduction of the position.
// Group play takes longer with each voice scanned.
// Reset is synchronous and active low; the sample store is not cleared.
// A stalled result beat waits in the output register while the next request
// is taken in.
// ----------------------------------------------------------------------------
module interpolating_voice_mixer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // voice, voice_last, sample_addr, sample_value, base_addr, length,
    // volume, speed, loop_enable, zero pad
    input  logic [119:0] s_tdata,
    // req_type
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // left, right, voice_started, playing, zero pad
    output logic [39:0]  m_tdata
);

    ivm_pkg::ivm_cmd_t  cmd;
    ivm_pkg::ivm_stat_t stat;
    logic signed [15:0] left, right;
    logic [3:0]         voice_started;
    logic               playing;

    ivm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ivm_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .in_req_type       (s_tuser),
        .in_voice          (s_tdata[3:0]),
        .in_voice_last     (s_tdata[7:4]),
        .in_sample_addr    (s_tdata[23:8]),
        .in_sample_value   (s_tdata[39:24]),
        .in_base_addr      (s_tdata[55:40]),
        .in_length         (s_tdata[72:56]),
        .in_volume         (s_tdata[88:73]),
        .in_speed          (s_tdata[112:89]),
        .in_loop_enable    (s_tdata[113]),
        .out_left          (left),
        .out_right         (right),
        .out_voice_started (voice_started),
        .out_playing       (playing)
    );

    assign m_tdata = {3'b000, playing, voice_started, right, left};

endmodule

// ===== hdl/ivm_checker.sv =====
// ----------------------------------------------------------------------------
// ivm_checker
// Port-level checks on the mixer's request and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ivm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);

    // hold a stalled result beat
    `IVM_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // one request in flight: ready drops after each accepted beat
    `IVM_ASSERT_NEXT(a_one_req, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a query answer carries nothing else
    `IVM_ASSERT_NOW(a_query_only, aclk, aresetn, !(m_tvalid && m_tdata[36]) || (m_tdata[35:0] == 36'd0))
    // a group start report carries no audio
    `IVM_ASSERT_NOW(a_group_only, aclk, aresetn, !(m_tvalid && (m_tdata[35:32] != 4'd0)) || ((m_tdata[31:0] == 32'd0) && !m_tdata[36]))

endmodule

bind interpolating_voice_mixer ivm_checker u_ivm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/interpolating_voice_mixer_tb.sv =====
// ----------------------------------------------------------------------------
// interpolating_voice_mixer_tb
// Self-checking bench for the voice mixer. Requests are sent as beats on the
// s_ side. An internal model of the voices and the sample store predicts the
// result beat for each accepted request. Result beats on the m_ side are
// compared field by field, in order. Directed cases cover saturation, wrap,
// zero and full length, group play and stop; random traffic follows under
// several idle and stall mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module interpolating_voice_mixer_tb;

    localparam int REGION_BASE = 65528;   // written sample region wraps 65528..55
    localparam int REGION_LEN  = 64;
    localparam int WDOG_LIMIT  = 5000;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [3:0]         started;
        logic               playing;
    } frame_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;

    // model state
    logic signed [15:0] wave_mem [0:65535];
    logic [15:0]        v_base [ivm_pkg::NUM_VOICES];
    logic [16:0]        v_len  [ivm_pkg::NUM_VOICES];
    longint unsigned    v_pos  [ivm_pkg::NUM_VOICES];
    logic [23:0]        v_step [ivm_pkg::NUM_VOICES];
    logic [15:0]        v_gain [ivm_pkg::NUM_VOICES];
    logic               v_loop [ivm_pkg::NUM_VOICES];
    logic               v_on   [ivm_pkg::NUM_VOICES];

    frame_t frames_due[$];
    int     err_cnt = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     hold_cnt = 0;
    bit     hold_req = 0;
    int     quiet_cycles = 0;

    interpolating_voice_mixer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------ model
    // voice registers as they stand after reset
    task automatic model_reset();
        int i;
        for (i = 0; i < ivm_pkg::NUM_VOICES; i++) begin
            v_base[i] = '0;
            v_len[i]  = 17'd1;
            v_pos[i]  = 0;
            v_step[i] = 24'h010000;
            v_gain[i] = '0;
            v_loop[i] = 1'b0;
            v_on[i]   = 1'b0;
        end
    endtask

    function automatic longint word_at(int v, longint unsigned idx);
        longint unsigned len;
        longint unsigned a;
        len = (v_len[v] == 0) ? 1 : v_len[v];
        a = (v_base[v] + idx % len) % 65536;
        return longint'(wave_mem[a]);
    endfunction

    // add one interpolated, scaled read to a channel sum and clamp
    function automatic longint voice_tap(int v, longint acc, int offs);
        longint unsigned ip;
        longint fr, s1, s2, num, r;
        ip  = (v_pos[v] >> ivm_pkg::FRAC_BITS) + offs;
        fr  = longint'(v_pos[v] & 64'hFFFF);
        s1  = word_at(v, ip) * longint'(v_gain[v]);
        s2  = word_at(v, ip + 1) * longint'(v_gain[v]);
        num = acc * (64'sd1 <<< 32) + s1 * 65536 + fr * (s2 - s1);
        r   = num / (64'sd1 <<< 32);
        if (r > ivm_pkg::PCM_MAX) r = ivm_pkg::PCM_MAX;
        else if (r < ivm_pkg::PCM_MIN) r = ivm_pkg::PCM_MIN;
        return r;
    endfunction

    function automatic frame_t apply_request(ivm_pkg::ivm_req_t rq, logic [119:0] d);
        frame_t f;
        int v, vl, i;
        longint l, r;
        longint unsigned lim;
        bit hit;
        f = '{0, 0, 0, 0};
        v  = d[3:0];
        vl = d[7:4];
        l = 0;
        r = 0;
        case (rq)
            ivm_pkg::REQ_TICK: begin
                for (i = 0; i < ivm_pkg::NUM_VOICES; i++) begin
                    if (v_on[i]) begin
                        l = voice_tap(i, l, 0);
                        r = voice_tap(i, r, 1);
                        v_pos[i] += v_step[i];
                        lim = longint'((v_len[i] == 0) ? 1 : v_len[i]) << ivm_pkg::FRAC_BITS;
                        if (v_pos[i] >= lim) begin
                            if (v_loop[i]) v_pos[i] = v_pos[i] % lim;
                            else begin
                                v_pos[i] = 0;
                                v_on[i] = 0;
                            end
                        end
                    end
                end
                f.left = l[15:0];
                f.right = r[15:0];
            end
            ivm_pkg::REQ_WRITE: wave_mem[d[23:8]] = d[39:24];
            ivm_pkg::REQ_SET: begin
                v_base[v] = d[55:40];
                v_len[v]  = d[72:56];
                v_gain[v] = d[88:73];
                v_step[v] = d[112:89];
                v_loop[v] = d[113];
                v_pos[v]  = 0;
                v_on[v]   = 0;
            end
            ivm_pkg::REQ_PLAY: begin
                v_pos[v] = 0;
                v_on[v] = 1;
            end
            ivm_pkg::REQ_STOP: begin
                v_pos[v] = 0;
                v_on[v] = 0;
            end
            ivm_pkg::REQ_STOP_ALL: begin
                for (i = 0; i < ivm_pkg::NUM_VOICES; i++) begin
                    v_pos[i] = 0;
                    v_on[i] = 0;
                end
            end
            ivm_pkg::REQ_GROUP: begin
                hit = 0;
                for (i = v; i <= vl && !hit; i++) begin
                    if (!v_on[i]) begin
                        hit = 1;
                        f.started = i;
                    end
                end
                if (!hit) f.started = v;
                v_pos[f.started] = 0;
                v_on[f.started] = 1;
            end
            default: f.playing = v_on[v];
        endcase
        return f;
    endfunction

    function automatic logic [119:0] pack_req(int v, int vl, int sa, int sv, int base,
                                              int len, int vol, int spd, bit lp);
        logic [119:0] d;
        d = '0;
        d[3:0] = v;
        d[7:4] = vl;
        d[23:8] = sa;
        d[39:24] = sv;
        d[55:40] = base;
        d[72:56] = len;
        d[88:73] = vol;
        d[112:89] = spd;
        d[113] = lp;
        return d;
    endfunction

    // ---------------------------------------------------------------- driving
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_cnt <= 400;
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_req(ivm_pkg::ivm_req_t rq, logic [119:0] d);
        frame_t f;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= rq;
        do @(posedge aclk); while (!s_tready);
        f = apply_request(rq, d);
        frames_due.push_back(f);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
    endtask

    // set a voice to a sound that stays inside the written region
    task automatic set_voice_safe(int v);
        int r, len, spd;
        r = $urandom_range(REGION_LEN - 1);
        spd = ($urandom_range(9) == 0) ? $urandom_range(24'hFFFFFF) : $urandom_range(24'h30000);
        case ($urandom_range(19))
            0: len = 0;
            1: begin
                len = (r <= REGION_LEN - 3) ? 65536 : 1;
                spd = 0;
            end
            default: len = $urandom_range(REGION_LEN - r, 1);
        endcase
        send_req(ivm_pkg::REQ_SET, pack_req(v, $urandom_range(15), $urandom_range(65535),
                 $urandom_range(65535), (REGION_BASE + r) % 65536, len,
                 $urandom_range(65535), spd, $urandom_range(1)));
    endtask

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        frame_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[15:0], 0);
            end else begin
                w = frames_due.pop_front();
                if (m_tdata[15:0] !== w.left)
                    report_mismatch("left", $signed(m_tdata[15:0]), w.left);
                if (m_tdata[31:16] !== w.right)
                    report_mismatch("right", $signed(m_tdata[31:16]), w.right);
                if (m_tdata[35:32] !== w.started)
                    report_mismatch("voice_started", m_tdata[35:32], w.started);
                if (m_tdata[36] !== w.playing)
                    report_mismatch("playing", m_tdata[36], w.playing);
            end
        end
    end

    // watchdog: stop when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------ tests
    task automatic test_preload();
        int i, a, val;
        for (i = 0; i < REGION_LEN; i++) begin
            a = (REGION_BASE + i) % 65536;
            if (a < 4) val = 32767;
            else if (a < 8) val = -32768;
            else val = $urandom_range(65535);
            send_req(ivm_pkg::REQ_WRITE, pack_req(0, 0, a, val, 0, 0, 0, 0, 0));
        end
        // far write, never read back
        send_req(ivm_pkg::REQ_WRITE,
                 pack_req(15, 15, 16'h8000, 16'h5AA5, 16'hFFFF, 0, 0, 0, 1));
    endtask

    task automatic test_directed();
        int v;
        // loop across the store wrap with fractional steps
        send_req(ivm_pkg::REQ_SET, pack_req(0, 0, 0, 0, REGION_BASE, 16, 65535, 24'h018000, 1));
        send_req(ivm_pkg::REQ_PLAY, pack_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
        repeat (3) send_req(ivm_pkg::REQ_TICK, '0);
        send_req(ivm_pkg::REQ_QUERY, pack_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero length acts as one; full length with no step
        send_req(ivm_pkg::REQ_SET, pack_req(1, 0, 0, 0, 10, 0, 40000, 24'h8000, 1));
        send_req(ivm_pkg::REQ_SET, pack_req(2, 0, 0, 0, 12, 65536, 20000, 0, 0));
        // saturate high and low
        for (v = 3; v < 6; v++)
            send_req(ivm_pkg::REQ_SET, pack_req(v, 0, 0, 0, 0, 4, 65535, 24'h010000, 0));
        send_req(ivm_pkg::REQ_SET, pack_req(6, 0, 0, 0, 4, 4, 65535, 24'hFFFFFF, 0));
        send_req(ivm_pkg::REQ_SET, pack_req(7, 0, 0, 0, 4, 4, 65535, 24'hFFFFFF, 1));
        send_req(ivm_pkg::REQ_GROUP, pack_req(1, 15, 0, 0, 0, 0, 0, 0, 0));
        send_req(ivm_pkg::REQ_GROUP, pack_req(1, 15, 0, 0, 0, 0, 0, 0, 0));
        for (v = 3; v < 8; v++)
            send_req(ivm_pkg::REQ_PLAY, pack_req(v, 0, 0, 0, 0, 0, 0, 0, 0));
        repeat (2) send_req(ivm_pkg::REQ_TICK, '0);
        // empty range retriggers the first voice
        send_req(ivm_pkg::REQ_GROUP, pack_req(9, 3, 0, 0, 0, 0, 0, 0, 0));
        send_req(ivm_pkg::REQ_STOP, pack_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(ivm_pkg::REQ_TICK, '0);
        send_req(ivm_pkg::REQ_STOP_ALL, '0);
        send_req(ivm_pkg::REQ_QUERY, pack_req(9, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(ivm_pkg::REQ_TICK, '0);
    endtask

    task automatic test_random(int n, int idle, int stall);
        int i, k, v, a;
        idle_pct = idle;
        stall_pct = stall;
        for (i = 0; i < n; i++) begin
            k = $urandom_range(99);
            v = $urandom_range(15);
            if (k < 30) begin
                send_req(ivm_pkg::REQ_TICK, pack_req(v, $urandom_range(15),
                         $urandom_range(65535), $urandom_range(65535), 0, 0, 0, 0, 0));
            end else if (k < 40) begin
                a = ($urandom_range(3) == 0) ? $urandom_range(65535)
                    : (REGION_BASE + $urandom_range(REGION_LEN - 1)) % 65536;
                send_req(ivm_pkg::REQ_WRITE,
                         pack_req(v, 0, a, $urandom_range(65535), 0, 0, 0, 0, 0));
            end else if (k < 60) begin
                // wild settings, immediately replaced by a safe one
                if ($urandom_range(6) == 0)
                    send_req(ivm_pkg::REQ_SET, pack_req(v, $urandom_range(15), 0, 0,
                             $urandom_range(65535), $urandom_range(131071),
                             $urandom_range(65535), $urandom_range(24'hFFFFFF),
                             $urandom_range(1)));
                set_voice_safe(v);
            end else if (k < 75) begin
                send_req(ivm_pkg::REQ_PLAY, pack_req(v, 0, 0, 0, 0, 0, 0, 0, 0));
            end else if (k < 80) begin
                send_req(ivm_pkg::REQ_STOP, pack_req(v, 0, 0, 0, 0, 0, 0, 0, 0));
            end else if (k < 83) begin
                send_req(ivm_pkg::REQ_STOP_ALL, '0);
            end else if (k < 93) begin
                send_req(ivm_pkg::REQ_GROUP,
                         pack_req(v, $urandom_range(15), 0, 0, 0, 0, 0, 0, 0));
            end else begin
                send_req(ivm_pkg::REQ_QUERY, pack_req(v, 0, 0, 0, 0, 0, 0, 0, 0));
            end
        end
    endtask

    task automatic test_backpressure();
        int v;
        idle_pct = 0;
        stall_pct = 0;
        for (v = 0; v < ivm_pkg::NUM_VOICES; v++)
            send_req(ivm_pkg::REQ_PLAY, pack_req(v, 0, 0, 0, 0, 0, 0, 0, 0));
        hold_req = 1;
        repeat (30) send_req(ivm_pkg::REQ_TICK, '0);
    endtask

    initial begin
        model_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_preload();
        test_directed();
        test_random(100, 0, 0);
        drain();
        test_random(100, 48, 0);
        test_backpressure();
        test_random(100, 0, 48);
        drain();
        test_random(100, 19, 19);
        drain();
        repeat (500) @(posedge aclk);
        if (err_cnt == 0 && frames_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== interpolating_voice_mixer.f =====
+incdir+hdl
hdl/ivm_pkg.sv
hdl/ivm_datapath.sv
hdl/ivm_ctrl.sv
hdl/interpolating_voice_mixer.sv
hdl/ivm_checker.sv
tb/interpolating_voice_mixer_tb.sv
